// File: rtl/core/sma_pkg.sv
`timescale 1ns / 1ps

package sma_pkg;

   // Fixed field widths of the bar and result items and of the length register.
   localparam int PRICE_W   = 48;
   localparam int TIME_W    = 64;
   localparam int CSR_LEN_W = 11;

   // Window length after reset, before saturation to the ring depth.
   localparam int LEN_RESET = 20;

   typedef enum logic [1:0] {
      FAULT_NONE     = 2'd0,
      FAULT_INVALID  = 2'd1,
      FAULT_BACKWARD = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FETCH,
      ST_SUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Status returned by the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/core/simple_moving_average_bar_top.sv
`timescale 1ns / 1ps

// Simple moving average over price bars.
// Bars arrive on the req_ channel (close price and close timestamp); each
// transfer yields exactly one result transfer on the rsp_ channel, in order.
// A transfer takes place at a rising edge where valid is high and stall is low.
// The window length is written through csr_wr_en / csr_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// A write also empties the window. A faulted bar goes from the check state
// straight to the done state; one that leaves the window short of full passes
// through fetch and sum first. With a full window the mean comes from a radix-2
// serial divider that retires one quotient bit per cycle over the 58-bit
// running sum (SUM_W in general). The next bar waits until the last is done.
// req_stall is high while a bar is being worked on. A finished result sits in
// the output register; while the receiver stalls it holds there unchanged, and
// the block may take the next bar and work on it, waiting at the end until the
// output register is free.
// Synchronous reset empties the window and sets the length to 20. The price
// ring needs no clearing pass: only written entries are ever read.
module simple_moving_average_bar_top
   import sma_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [PRICE_W-1:0] req_close_price,
   input  logic signed [TIME_W-1:0]  req_close_time_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [TIME_W-1:0]  rsp_echo_time_ms,
   output logic signed [PRICE_W-1:0] rsp_average,
   output logic                      rsp_average_valid,
   output logic [1:0]                rsp_fault_code,
   output logic                      rsp_replaced_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_LEN_W-1:0]      csr_wr_data
);

   // Widths that follow from the ring depth.
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W  = PRICE_W + $clog2(MAX_WINDOW);
   localparam logic [LEN_W-1:0] LEN_AT_RESET =
      LEN_W'((LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET);

   state_type state_ff, state_in;

   // Latched bar.
   logic [PRICE_W-1:0] price_ff;
   logic [TIME_W-1:0]  time_ff;

   // Window state.
   logic [LEN_W-1:0]   eff_len_ff;
   logic [LEN_W-1:0]   fill_ff;
   logic [SLOT_W-1:0]  write_slot_ff;
   logic [SLOT_W-1:0]  newest_slot_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TIME_W-1:0]  last_time_ff;
   logic               time_seen_ff;

   // Per-bar working registers.
   logic [SLOT_W-1:0]  slot_ff;
   logic               replace_ff;
   logic               fresh_ff;
   logic [PRICE_W:0]   delta_ff;

   // Finished result, waiting for the output register.
   fault_type          res_fault_ff;
   logic [PRICE_W-1:0] res_avg_ff;
   logic               res_avg_valid_ff;
   logic               res_repl_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [TIME_W-1:0]  rsp_time_ff;
   logic [PRICE_W-1:0] rsp_avg_ff;
   logic               rsp_avg_valid_ff;
   fault_type          rsp_fault_ff;
   logic               rsp_repl_ff;

   logic               bad_input;
   logic               backward;
   logic               is_replace;
   logic               filling;
   logic [SLOT_W-1:0]  pick_slot;
   logic               out_free;
   logic               ring_rd_en;
   logic               ring_wr_en;
   logic [PRICE_W-1:0] ring_rd_data;
   logic [PRICE_W-1:0] old_price;
   logic [LEN_W-1:0]   fill_next;
   logic [LEN_W-1:0]   ws_next;
   logic [SUM_W-1:0]   sum_in;
   logic               div_start;
   div_stat_type       div_stat;
   logic [SUM_W-1:0]   div_quotient;
   logic [31:0]        cfg_len_wide;
   logic [LEN_W-1:0]   eff_len_in;

   // A written length of zero counts as one; one above the ring depth is
   // clipped to the depth.
   always_comb begin
      cfg_len_wide = 32'(csr_wr_data);
      if (cfg_len_wide == 32'd0) begin
         eff_len_in = LEN_W'(1);
      end else if (cfg_len_wide > 32'(MAX_WINDOW)) begin
         eff_len_in = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len_in = LEN_W'(cfg_len_wide);
      end
   end

   // Classification of the latched bar. Both timestamps are positive when
   // the order test matters, so an unsigned compare gives the signed order.
   assign bad_input  = (price_ff == '0) || price_ff[PRICE_W-1] ||
                       (time_ff == '0) || time_ff[TIME_W-1];
   assign backward   = time_seen_ff && (time_ff < last_time_ff);
   assign is_replace = time_seen_ff && (time_ff == last_time_ff);
   assign filling    = (fill_ff < eff_len_ff);

   always_comb begin
      if (is_replace) begin
         pick_slot = newest_slot_ff;
      end else if (filling) begin
         pick_slot = fill_ff[SLOT_W-1:0];
      end else begin
         pick_slot = write_slot_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign old_price = fresh_ff ? '0 : ring_rd_data;
   assign fill_next = fill_ff + LEN_W'(1);
   assign ws_next   = LEN_W'(write_slot_ff) + LEN_W'(1);
   assign sum_in    = sum_ff + SUM_W'($signed(delta_ff));

   // Next state and control strobes.
   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      ring_rd_en = 1'b0;
      ring_wr_en = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (bad_input || backward) begin
               state_in = ST_DONE;
            end else begin
               ring_rd_en = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ring_wr_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            if (fill_ff == eff_len_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the bar on its transfer.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         price_ff <= req_close_price;
         time_ff  <= req_close_time_ms;
      end
   end

   // Window state: reset and length writes empty it. An unfaulted bar that is not a
   // revision moves the slots as its ring entry is written; any unfaulted bar then updates the sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff     <= LEN_AT_RESET;
         fill_ff        <= '0;
         write_slot_ff  <= '0;
         newest_slot_ff <= '0;
         sum_ff         <= '0;
         last_time_ff   <= '0;
         time_seen_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         eff_len_ff     <= eff_len_in;
         fill_ff        <= '0;
         write_slot_ff  <= '0;
         newest_slot_ff <= '0;
         sum_ff         <= '0;
         last_time_ff   <= '0;
         time_seen_ff   <= 1'b0;
      end else begin
         if (state_ff == ST_FETCH && !replace_ff) begin
            newest_slot_ff <= slot_ff;
            last_time_ff   <= time_ff;
            time_seen_ff   <= 1'b1;
            if (fresh_ff) begin
               fill_ff       <= fill_next;
               write_slot_ff <= (fill_next >= eff_len_ff) ? '0 : fill_next[SLOT_W-1:0];
            end else begin
               write_slot_ff <= (ws_next >= eff_len_ff) ? '0 : ws_next[SLOT_W-1:0];
            end
         end
         if (state_ff == ST_SUM) begin
            sum_ff <= sum_in;
         end
      end
   end

   // Per-bar working registers and the finished result.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         slot_ff          <= pick_slot;
         replace_ff       <= is_replace;
         fresh_ff         <= !is_replace && filling;
         res_avg_ff       <= '0;
         res_avg_valid_ff <= 1'b0;
         res_repl_ff      <= 1'b0;
         if (bad_input) begin
            res_fault_ff <= FAULT_INVALID;
         end else if (backward) begin
            res_fault_ff <= FAULT_BACKWARD;
         end else begin
            res_fault_ff <= FAULT_NONE;
         end
      end
      if (state_ff == ST_FETCH) begin
         // The new price less the one it displaces; zero is displaced while
         // the window is still filling.
         delta_ff <= {1'b0, price_ff} - {1'b0, old_price};
      end
      if (state_ff == ST_SUM) begin
         res_repl_ff <= replace_ff;
      end
      if (state_ff == ST_DIVIDE && div_stat.done) begin
         res_avg_ff       <= div_quotient[PRICE_W-1:0];
         res_avg_valid_ff <= 1'b1;
      end
   end

   // Output register: loaded when the result is finished and the slot is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_time_ff      <= time_ff;
         rsp_avg_ff       <= res_avg_ff;
         rsp_avg_valid_ff <= res_avg_valid_ff;
         rsp_fault_ff     <= res_fault_ff;
         rsp_repl_ff      <= res_repl_ff;
      end
   end

   sma_ring #(
      .DEPTH  (MAX_WINDOW),
      .ADDR_W (SLOT_W),
      .DATA_W (PRICE_W)
   ) u_ring (
      .clock   (clock),
      .rd_en   (ring_rd_en),
      .rd_addr (pick_slot),
      .rd_data (ring_rd_data),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (price_ff)
   );

   sma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (eff_len_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echo_time_ms  = $signed(rsp_time_ff);
   assign rsp_average       = $signed(rsp_avg_ff);
   assign rsp_average_valid = rsp_avg_valid_ff;
   assign rsp_fault_code    = rsp_fault_ff;
   assign rsp_replaced_last = rsp_repl_ff;

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_len_ff)
      else $error("fill count above window length");

   a_slot_tracks_fill : assert property (@(posedge clock) disable iff (reset)
      (fill_ff < eff_len_ff) |-> (LEN_W'(write_slot_ff) == fill_ff))
      else $error("write slot out of step with fill count while filling");

   a_divide_only_full : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |->
         ((fill_ff == eff_len_ff) && (div_stat.busy || div_stat.done)))
      else $error("divide state without a full window or a running divider");

   a_average_not_faulted : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_avg_valid_ff) |-> (rsp_fault_ff == FAULT_NONE))
      else $error("average reported on a faulted bar");

endmodule

// File: rtl/core/sma_ring.sv
`timescale 1ns / 1ps

module sma_ring
   import sma_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   // Price storage; contents are undefined until written.
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sma_div.sv
`timescale 1ns / 1ps

module sma_div
   import sma_pkg::*;
#(
   parameter int DIVIDEND_W = 58,
   parameter int DIVISOR_W  = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type          stat,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  divisor_ff;
   logic [DIVIDEND_W-1:0] quo_ff;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // One quotient bit per cycle: the dividend leaves the shift register at
   // the top while the quotient bits enter at the bottom.
   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, divisor_ff};
   assign fits    = (shifted >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_LAST;
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= '0;
         quo_ff     <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_start_when_free : assert property (@(posedge clock) disable iff (reset)
      start |-> (!busy_ff && (divisor != '0)))
      else $error("divider started while busy or with zero divisor");

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished run");

endmodule

// File: tb/sv/tb_simple_moving_average_bar_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the moving average over price bars. A driver and a
// monitor run as clocked processes; the monitor predicts every bar it sees
// transferred and compares each result transfer with the oldest prediction.
module tb_simple_moving_average_bar_top;
   import sma_pkg::*;

   localparam int MAX_WINDOW   = 1024;
   localparam int SUM_W        = 58;
   localparam int STEP_MAX     = 100000;
   localparam int LONG_HOLD    = 500;
   localparam int DRAIN_CYCLES = 80;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PRINT_CAP    = 100;
   localparam int PHASES       = 8;

   localparam logic [PRICE_W-1:0] PRICE_MAX = {1'b0, {(PRICE_W-1){1'b1}}};
   localparam logic [PRICE_W-1:0] PRICE_MIN = {1'b1, {(PRICE_W-1){1'b0}}};
   localparam logic [TIME_W-1:0]  TIME_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic [TIME_W-1:0]  TIME_MIN  = {1'b1, {(TIME_W-1){1'b0}}};

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TIME_W-1:0]  time_ms;
   } bar_type;

   typedef struct packed {
      logic [TIME_W-1:0]  echo_time_ms;
      logic [PRICE_W-1:0] average;
      logic               average_valid;
      fault_type          fault_code;
      logic               replaced_last;
   } sma_result_type;

   // Block ports. Every input holds a known value from time zero.
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [PRICE_W-1:0] req_close_price = '0;
   logic signed [TIME_W-1:0]  req_close_time_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [TIME_W-1:0]  rsp_echo_time_ms;
   logic signed [PRICE_W-1:0] rsp_average;
   logic                      rsp_average_valid;
   logic [1:0]                rsp_fault_code;
   logic                      rsp_replaced_last;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_LEN_W-1:0]      csr_wr_data = '0;

   // Our own copy of the averaging state, kept in step with the block.
   logic [CSR_LEN_W-1:0] sma_window;
   logic [PRICE_W-1:0]   sma_ring [MAX_WINDOW];
   int unsigned          sma_fill;
   int unsigned          sma_wslot;
   int unsigned          sma_nslot;
   logic [SUM_W-1:0]     sma_sum;
   logic [TIME_W-1:0]    sma_last_time;
   logic                 sma_time_seen;

   // Bars waiting to be offered, and the results that are owed to us.
   bar_type        pending_bars [$];
   sma_result_type expected_results [$];
   bar_type        drive_bar;
   sma_result_type oldest_expected;

   // Stimulus control, written by the sequencing process at falling edges.
   int unsigned       send_idle_pct = 0;
   int unsigned       recv_idle_pct = 0;
   bit                hold_request = 1'b0;
   logic [TIME_W-1:0] last_bar_ms = '0;

   int unsigned hold_count = 0;
   bit          hold_done = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned averages_seen = 0;
   int unsigned replacements_seen = 0;
   int unsigned invalid_seen = 0;
   int unsigned backward_seen = 0;
   int unsigned windows_run = 0;

   int phase_window [PHASES] = '{20, 0, 1, 2, 7, 2047, 1024, 37};
   int phase_items  [PHASES] = '{110, 80, 80, 100, 200, 1400, 40, 80};

   simple_moving_average_bar_top #(
      .MAX_WINDOW(MAX_WINDOW)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_close_price   (req_close_price),
      .req_close_time_ms (req_close_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_echo_time_ms  (rsp_echo_time_ms),
      .rsp_average       (rsp_average),
      .rsp_average_valid (rsp_average_valid),
      .rsp_fault_code    (rsp_fault_code),
      .rsp_replaced_last (rsp_replaced_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // 20 ns period: ten nanoseconds low, then ten high.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // A new window length always starts from an empty window, exactly as a
   // write to the block does. The ring itself is left alone, since an entry
   // is only ever read back after it has been written.
   function automatic void load_window_length(logic [CSR_LEN_W-1:0] value);
      sma_window    = value;
      sma_fill      = 0;
      sma_wslot     = 0;
      sma_nslot     = 0;
      sma_sum       = '0;
      sma_last_time = '0;
      sma_time_seen = 1'b0;
   endfunction

   // Works out the result of one bar and moves our state on accordingly.
   function automatic sma_result_type predict_bar(logic [PRICE_W-1:0] price,
                                                  logic [TIME_W-1:0] t);
      sma_result_type   r;
      int unsigned      len;
      int unsigned      slot;
      logic [SUM_W-1:0] quotient;
      // A zero length behaves as one, and anything above the ring depth is
      // clipped to the depth.
      if (sma_window == 0) len = 1;
      else if (sma_window > MAX_WINDOW) len = MAX_WINDOW;
      else len = sma_window;
      r.echo_time_ms  = t;
      r.average       = '0;
      r.average_valid = 1'b0;
      r.fault_code    = FAULT_NONE;
      r.replaced_last = 1'b0;
      // Non-positive prices or timestamps are refused and change nothing.
      if (price == '0 || price[PRICE_W-1] || t == '0 || t[TIME_W-1]) begin
         r.fault_code = FAULT_INVALID;
         return r;
      end
      // Both timestamps are positive here, so an unsigned compare will do.
      if (sma_time_seen && t < sma_last_time) begin
         r.fault_code = FAULT_BACKWARD;
         return r;
      end
      if (sma_time_seen && t == sma_last_time) begin
         // A revised bar overwrites the newest entry in place.
         slot = sma_nslot;
         sma_sum = sma_sum - SUM_W'(sma_ring[slot]) + SUM_W'(price);
         sma_ring[slot] = price;
         r.replaced_last = 1'b1;
      end else begin
         if (sma_fill < len) begin
            slot = sma_fill;
            sma_nslot = slot;
            sma_ring[slot] = price;
            sma_sum = sma_sum + SUM_W'(price);
            sma_fill = sma_fill + 1;
            sma_wslot = (sma_fill >= len) ? 0 : sma_fill;
         end else begin
            // Full window: the oldest entry gives way to the new bar.
            slot = sma_wslot;
            sma_nslot = slot;
            sma_sum = sma_sum - SUM_W'(sma_ring[slot]) + SUM_W'(price);
            sma_ring[slot] = price;
            sma_wslot = (sma_wslot + 1 >= len) ? 0 : sma_wslot + 1;
         end
         sma_last_time = t;
         sma_time_seen = 1'b1;
      end
      if (sma_fill == len) begin
         quotient = sma_sum / SUM_W'(len);
         r.average = quotient[PRICE_W-1:0];
         r.average_valid = 1'b1;
      end
      return r;
   endfunction

   // Draws one bar. Most bars extend the timeline with a fresh positive
   // price; the rest revise the newest bar, step back in time, are malformed
   // or are entirely random. last_bar_ms follows the timeline the block sees.
   function automatic bar_type make_random_bar();
      bar_type     b;
      int unsigned pick;
      int unsigned span;
      pick = $urandom_range(99);
      if ($urandom_range(9) < 6) b.price = PRICE_W'($urandom_range(32'hFFFF_FFFF, 1));
      else b.price = {1'b0, 15'($urandom), 32'($urandom)};
      if (b.price == '0) b.price = PRICE_W'(1);
      b.time_ms = last_bar_ms + TIME_W'($urandom_range(STEP_MAX, 1));
      if (pick < 2 && last_bar_ms < (64'd1 << 61)) begin
         // A long jump forward, so that the upper timestamp bits move too.
         b.time_ms = last_bar_ms + {6'b0, 26'($urandom), 32'($urandom)};
      end else if (pick < 72) begin
         // An ordinary next bar, already drawn above.
      end else if (pick < 82) begin
         b.time_ms = last_bar_ms;
      end else if (pick < 86 && last_bar_ms > 1) begin
         span = (last_bar_ms > STEP_MAX) ? STEP_MAX : int'(last_bar_ms - 1);
         b.time_ms = last_bar_ms - TIME_W'($urandom_range(span, 1));
      end else if (pick < 96) begin
         case ($urandom_range(3))
            0: b.price = '0;
            1: b.price = {1'b1, 15'($urandom), 32'($urandom)};
            2: b.time_ms = '0;
            default: b.time_ms = {1'b1, 31'($urandom), 32'($urandom)};
         endcase
      end else begin
         b.price   = {16'($urandom), 32'($urandom)};
         b.time_ms = {$urandom, $urandom};
      end
      if (b.price != '0 && !b.price[PRICE_W-1] && b.time_ms != '0 &&
          !b.time_ms[TIME_W-1] && b.time_ms > last_bar_ms) begin
         last_bar_ms = b.time_ms;
      end
      return b;
   endfunction

   task automatic queue_bar(input logic [PRICE_W-1:0] price,
                            input logic [TIME_W-1:0] t);
      bar_type b;
      b.price   = price;
      b.time_ms = t;
      pending_bars.push_back(b);
   endtask

   // One line per mismatch, with a cap so that a broken block cannot flood
   // the log; every mismatch is still counted.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("Mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                  results_checked, what, got, want);
      error_count = error_count + 1;
   endtask

   // Returns once every bar has been transferred and every result has come.
   task automatic wait_until_drained();
      while (pending_bars.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Driver. A new bar is offered only once the previous one has been
   // transferred or nothing was on offer; a stalled bar is held unchanged.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_bars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_bar = pending_bars.pop_front();
            req_valid         <= 1'b1;
            req_close_price   <= drive_bar.price;
            req_close_time_ms <= drive_bar.time_ms;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Normally it stalls at random; once asked, it holds off for a
   // long stretch of its own counting, so that the block backs up into its
   // input while the driver keeps offering bars.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_request && !hold_done) begin
         if (hold_count < LONG_HOLD) begin
            rsp_stall  <= 1'b1;
            hold_count <= hold_count + 1;
         end else begin
            rsp_stall <= 1'b0;
            hold_done <= 1'b1;
         end
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor. Inputs change only through nonblocking assignments, so the
   // values seen here are those that the block itself samples at this edge.
   // The prediction is queued before the check, though no result can leave
   // the block in the cycle its bar arrives.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_results.push_back(predict_bar(req_close_price, req_close_time_ms));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no bar outstanding",
                               rsp_echo_time_ms, '0);
            end else begin
               oldest_expected = expected_results.pop_front();
               if (rsp_echo_time_ms !== oldest_expected.echo_time_ms)
                  report_mismatch("echo_time_ms", rsp_echo_time_ms,
                                  oldest_expected.echo_time_ms);
               if (rsp_average !== oldest_expected.average)
                  report_mismatch("average", {16'b0, rsp_average},
                                  {16'b0, oldest_expected.average});
               if (rsp_average_valid !== oldest_expected.average_valid)
                  report_mismatch("average_valid", {63'b0, rsp_average_valid},
                                  {63'b0, oldest_expected.average_valid});
               if (rsp_fault_code !== oldest_expected.fault_code)
                  report_mismatch("fault_code", {62'b0, rsp_fault_code},
                                  {62'b0, oldest_expected.fault_code});
               if (rsp_replaced_last !== oldest_expected.replaced_last)
                  report_mismatch("replaced_last", {63'b0, rsp_replaced_last},
                                  {63'b0, oldest_expected.replaced_last});
               if (oldest_expected.average_valid) averages_seen = averages_seen + 1;
               if (oldest_expected.replaced_last) replacements_seen = replacements_seen + 1;
               if (oldest_expected.fault_code == FAULT_INVALID)
                  invalid_seen = invalid_seen + 1;
               if (oldest_expected.fault_code == FAULT_BACKWARD)
                  backward_seen = backward_seen + 1;
            end
            results_checked = results_checked + 1;
         end
      end
   end

   // Watchdog. The limit is several times the slowest healthy run, in which
   // every bar needs the full divide and waits on the receiver.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Sequencing. Each phase sets a window length while the block is idle,
   // chooses how both sides idle, and queues its bars. Between phases the
   // sender pauses until every owed result has been transferred.
   initial begin
      int p;
      int n;
      load_window_length(CSR_LEN_W'(LEN_RESET));
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            wait_until_drained();
            // Leave the divider time to finish, whatever it may still hold.
            repeat (DRAIN_CYCLES) @(negedge clock);
            if (p == PHASES - 1) phase_window[p] = $urandom_range(60, 3);
            @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= CSR_LEN_W'(phase_window[p]);
            @(posedge clock);
            csr_wr_en <= 1'b0;
            load_window_length(CSR_LEN_W'(phase_window[p]));
            @(negedge clock);
            last_bar_ms = '0;
         end
         // Sender idles lightly first while the receiver idles heavily, then
         // the roles swap, and the final phases run flat out on both sides.
         if (p < 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 45;
         end else if (p < 5) begin
            send_idle_pct = 45;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 0) begin
            // Directed opening at the reset length: the smallest bar, the
            // largest price, a revised bar, a step back in time, and every
            // kind of malformed price and timestamp.
            queue_bar(PRICE_W'(1), TIME_W'(1));
            queue_bar(PRICE_MAX, TIME_W'(2));
            queue_bar(PRICE_W'(5), TIME_W'(2));
            queue_bar(PRICE_W'(7), TIME_W'(1));
            queue_bar('0, TIME_W'(3));
            queue_bar('1, TIME_W'(3));
            queue_bar(PRICE_MIN, TIME_W'(3));
            queue_bar(PRICE_W'(9), '0);
            queue_bar(PRICE_W'(9), '1);
            queue_bar(PRICE_W'(9), TIME_MIN);
            queue_bar(PRICE_MAX, TIME_W'(3));
            queue_bar(PRICE_MAX, TIME_W'(4));
            queue_bar(PRICE_W'(3), TIME_W'(4));
            last_bar_ms = TIME_W'(4);
         end
         for (n = 0; n < phase_items[p]; n++)
            pending_bars.push_back(make_random_bar());
         if (p == 2) begin
            // With a window of one the mean is the bar itself, so the top
            // price and the latest possible timestamp are checked directly.
            queue_bar(PRICE_MAX, TIME_MAX);
            queue_bar(PRICE_W'(1), TIME_MAX);
         end
         if (p == 4) hold_request = 1'b1;
         windows_run = windows_run + 1;
      end
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Checked %0d bars over %0d window lengths, including one long output stall.",
               results_checked, windows_run);
      $display("Among them %0d means, %0d revised bars, %0d malformed and %0d out-of-order bars.",
               averages_seen, replacements_seen, invalid_seen, backward_seen);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
